// ===== src/csv_unsigned_field_parser_assert.svh =====
// Assertion macros for the CSV unsigned field parser.
// Used by the top level only; needs nothing else.
`ifndef CSV_UNSIGNED_FIELD_PARSER_ASSERT_SVH
`define CSV_UNSIGNED_FIELD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSVU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/csvu_pkg.sv =====
// Shared types, character codes and field helpers for the CSV unsigned field parser.
// Used by csvu_parse, csvu_queue, csv_unsigned_field_parser and tb_top; depends on nothing.
package csvu_pkg;

  localparam int TEXT_CAP = 64;
  localparam int CNT_W    = $clog2(TEXT_CAP);
  localparam logic [CNT_W-1:0] KEEP_MAX = CNT_W'(TEXT_CAP - 1);
  localparam logic [CNT_W-1:0] SEP_GAP  = CNT_W'(3);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int LVL_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_PLAIN,
    PH_QUOTED,
    PH_AFTER
  } phase_t;

  typedef enum logic [1:0] {
    CV_PRE,
    CV_SIGN,
    CV_DIGITS,
    CV_DONE
  } cv_t;

  typedef struct packed {
    logic [63:0]      acc;
    logic [CNT_W-1:0] count;
    logic             sep_seen;
    logic [CNT_W-1:0] sep_pos;
    cv_t              cv;
    logic             neg;
    logic             ovf;
  } field_t;

  localparam field_t FIELD_CLEAR = '{
    acc: 64'd0, count: '0, sep_seen: 1'b0, sep_pos: '0,
    cv: CV_PRE, neg: 1'b0, ovf: 1'b0
  };

  // One finished field; the final value is formed at the output.
  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic        ovf;
    logic        bad;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  // Largest accumulator that can take digit d without passing 2^64-1.
  function automatic logic [63:0] digit_limit(input logic [3:0] d);
    logic [63:0] lim;
    lim = (d <= 4'd5) ? 64'h1999_9999_9999_9999 : 64'h1999_9999_9999_9998;
    return lim;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    logic sp;
    sp = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
         (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    return sp;
  endfunction

  function automatic field_t add_digit(input field_t f, input logic [3:0] d);
    field_t r;
    r = f;
    if (!f.ovf) begin
      if (f.acc > digit_limit(d)) begin
        r.ovf = 1'b1;
      end else begin
        r.acc = (f.acc << 3) + (f.acc << 1) + {60'd0, d};
      end
    end
    return r;
  endfunction

  // Keeps one character of field text and runs it through the converter.
  function automatic field_t keep_char(input field_t f, input logic [7:0] c);
    field_t r;
    logic   dig;
    r   = f;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (f.count < KEEP_MAX) begin
      r.count = f.count + CNT_W'(1);
      case (f.cv)
        CV_PRE: begin
          if (is_space(c)) begin
            r.cv = CV_PRE;
          end else if (c == CH_PLUS) begin
            r.cv = CV_SIGN;
          end else if (c == CH_MINUS) begin
            r.neg = 1'b1;
            r.cv  = CV_SIGN;
          end else if (dig) begin
            r.cv = CV_DIGITS;
            r    = add_digit(r, c[3:0]);
          end else begin
            r.cv = CV_DONE;
          end
        end
        CV_SIGN, CV_DIGITS: begin
          if (dig) begin
            r.cv = CV_DIGITS;
            r    = add_digit(r, c[3:0]);
          end else begin
            r.cv = CV_DONE;
          end
        end
        default: begin
          r.cv = f.cv;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/csvu_parse.sv =====
// Field parse state and the per-character step of the CSV unsigned field parser.
// Depends on csvu_pkg for the field and result types and the character helpers.
module csvu_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            record_end,
  output csvu_pkg::push_t push
);

  csvu_pkg::phase_t phase, phase_next, ph_mid;
  csvu_pkg::field_t fld, fld_next, base, mid;
  csvu_pkg::result_t res1, res2;

  logic is_nul, is_comma, is_quote, is_blank, bad_sep;
  logic emit1, emit2, bad1, do_keep, do_sep;

  assign is_nul   = (data_byte == csvu_pkg::CH_NUL);
  assign is_comma = (data_byte == csvu_pkg::CH_COMMA);
  assign is_quote = (data_byte == csvu_pkg::CH_QUOTE);
  assign is_blank = (data_byte == csvu_pkg::CH_SPACE) || (data_byte == csvu_pkg::CH_TAB);
  assign bad_sep  = fld.sep_seen && ((fld.count - fld.sep_pos) != csvu_pkg::SEP_GAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= csvu_pkg::PH_LEAD;
      fld   <= csvu_pkg::FIELD_CLEAR;
    end else if (take) begin
      phase <= phase_next;
      fld   <= fld_next;
    end
  end

  always_comb begin
    emit1   = 1'b0;
    bad1    = 1'b0;
    do_keep = 1'b0;
    do_sep  = 1'b0;
    ph_mid  = phase;
    unique case (phase)
      csvu_pkg::PH_LEAD: begin
        if (is_blank) begin
          ph_mid = csvu_pkg::PH_LEAD;
        end else if (is_comma) begin
          emit1 = 1'b1;
        end else if (is_quote) begin
          ph_mid = csvu_pkg::PH_QUOTED;
        end else begin
          do_keep = 1'b1;
          ph_mid  = csvu_pkg::PH_PLAIN;
        end
      end
      csvu_pkg::PH_PLAIN: begin
        if (is_comma) begin
          emit1  = 1'b1;
          ph_mid = csvu_pkg::PH_LEAD;
        end else begin
          do_keep = 1'b1;
        end
      end
      csvu_pkg::PH_QUOTED: begin
        if (is_quote) begin
          ph_mid = csvu_pkg::PH_AFTER;
        end else if (is_comma) begin
          if (bad_sep) begin
            emit1  = 1'b1;
            bad1   = 1'b1;
            ph_mid = csvu_pkg::PH_LEAD;
          end else begin
            do_sep = 1'b1;
          end
        end else begin
          do_keep = 1'b1;
        end
      end
      csvu_pkg::PH_AFTER: begin
        if (is_blank) begin
          ph_mid = csvu_pkg::PH_AFTER;
        end else if (is_comma) begin
          emit1  = 1'b1;
          ph_mid = csvu_pkg::PH_LEAD;
        end else if (is_quote) begin
          emit1  = 1'b1;
          ph_mid = csvu_pkg::PH_QUOTED;
        end else begin
          emit1   = 1'b1;
          do_keep = 1'b1;
          ph_mid  = csvu_pkg::PH_PLAIN;
        end
      end
      default: begin
        ph_mid = csvu_pkg::PH_LEAD;
      end
    endcase

    // A NUL byte closes the record at once and is not content.
    if (is_nul) begin
      emit1   = 1'b1;
      bad1    = 1'b0;
      do_keep = 1'b0;
      do_sep  = 1'b0;
      ph_mid  = csvu_pkg::PH_LEAD;
    end

    base = emit1 ? csvu_pkg::FIELD_CLEAR : fld;
    mid  = base;
    if (do_keep) begin
      mid = csvu_pkg::keep_char(base, data_byte);
    end
    if (do_sep) begin
      mid.sep_seen = 1'b1;
      mid.sep_pos  = base.count;
    end

    emit2 = record_end && !is_nul;

    res1 = '{acc: fld.acc, neg: fld.neg, ovf: fld.ovf, bad: bad1, last: is_nul};
    res2 = '{acc: mid.acc, neg: mid.neg, ovf: mid.ovf, bad: 1'b0, last: 1'b1};

    if (emit2) begin
      fld_next   = csvu_pkg::FIELD_CLEAR;
      phase_next = csvu_pkg::PH_LEAD;
    end else begin
      fld_next   = mid;
      phase_next = ph_mid;
    end

    push.n  = take ? ({1'b0, emit1} + {1'b0, emit2}) : 2'd0;
    push.r0 = emit1 ? res1 : res2;
    push.r1 = res2;
  end

endmodule

// ===== src/csvu_queue.sv =====
// Small result queue of the CSV unsigned field parser: up to two writes and one read a cycle.
// Depends on csvu_pkg for the result and push types and the queue sizes.
module csvu_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  csvu_pkg::push_t            push,
  input  logic                       pop,
  output csvu_pkg::result_t          head,
  output logic [csvu_pkg::LVL_W-1:0] level
);

  csvu_pkg::result_t mem [csvu_pkg::QDEPTH];

  logic [csvu_pkg::QPTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_plus;
  logic [csvu_pkg::LVL_W-1:0]  level_next;

  assign wr_ptr_plus = wr_ptr + csvu_pkg::QPTR_W'(1);
  assign level_next  = level + csvu_pkg::LVL_W'(push.n) - csvu_pkg::LVL_W'(pop);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + csvu_pkg::QPTR_W'(push.n);
      rd_ptr <= rd_ptr + csvu_pkg::QPTR_W'(pop);
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_plus] <= push.r1;
    end
  end

endmodule

// ===== src/csv_unsigned_field_parser.sv =====
// A field closed by an accepted byte goes into the result queue; out_valid follows the
// registered queue level. Throughput: one byte per cycle while each byte closes at most
// one field; a byte closing two fields (a comma carrying the record end) queues both,
// and in_ready falls while the four-entry result queue holds more than two fields.
// Reset: synchronous rst returns the parser to the leading-blank phase with an empty
// field and empties the result queue.
module csv_unsigned_field_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] field_value,
  output logic        bad_separator,
  output logic        saturated,
  output logic        last_field
);

`include "csv_unsigned_field_parser_assert.svh"

  // The parse stage holds the phase of the record and the field being built.
  // Each transfer on the input updates it in one step: the comma, quote and
  // blank handling picks which fields close, and the converter multiplies the
  // accumulator by ten and adds the digit, with the overflow test against a
  // fixed limit per digit. Up to two finished fields are written to the queue.
  csvu_pkg::push_t             push;
  csvu_pkg::result_t           head;
  logic [csvu_pkg::LVL_W-1:0]  level;
  logic                        take;
  logic                        pop;

  // Room for two more fields is always kept, so a byte is never taken that
  // could not store every field it closes.
  assign in_ready = (level <= csvu_pkg::LVL_W'(csvu_pkg::QDEPTH - 2));
  assign take     = in_valid && in_ready;

  csvu_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .record_end (record_end),
    .push       (push)
  );

  // The queue decouples the two sides: a stalled output does not stop the
  // input until the queue is nearly full.
  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;

  csvu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  // The sign and saturation are applied on the way out, so the parse step
  // carries only the raw accumulator. Saturation wins over the sign.
  always_comb begin
    if (head.ovf) begin
      field_value = '1;
    end else if (head.neg) begin
      field_value = 64'd0 - head.acc;
    end else begin
      field_value = head.acc;
    end
  end

  assign bad_separator = head.bad;
  assign saturated     = head.ovf;
  assign last_field    = head.last;

  // The queue can never hold more fields than it has entries.
  `CSVU_ASSERT_SAME(a_level_bound, clk, rst, 1'b1,
    level <= csvu_pkg::LVL_W'(csvu_pkg::QDEPTH), "result queue overfilled")

  // Nothing is written to the queue unless a byte is transferred.
  `CSVU_ASSERT_SAME(a_push_only_on_take, clk, rst, !take, push.n == 2'd0,
    "field written without an input transfer")

  // A NUL byte closes exactly one field, the final one of its record.
  `CSVU_ASSERT_SAME(a_nul_closes_one, clk, rst, take && (data_byte == csvu_pkg::CH_NUL),
    push.n == 2'd1 && push.r0.last, "NUL byte did not close the record once")

  // A byte that ends the record leaves a final field as the last one written.
  `CSVU_ASSERT_SAME(a_end_gives_last, clk, rst, take && record_end,
    (push.n == 2'd1 && push.r0.last) || (push.n == 2'd2 && push.r1.last),
    "record end gave no final field")

  // After a transfer that writes a field the output has something to offer.
  `CSVU_ASSERT_NEXT(a_push_shows, clk, rst, push.n != 2'd0, out_valid,
    "written field not offered on the output")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for csv_unsigned_field_parser: CSV bytes in, one parsed field per transfer out.
// Depends on csvu_pkg for the phase enums and TEXT_CAP; the expected fields come from a
// field parser kept inside the bench and are compared in order as the block hands them over.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTE_TARGET = 1450;
  localparam int unsigned SHOWN_MAX   = 10;

  localparam logic [7:0] C_NUL   = 8'h00;
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_SPACE = 8'h20;
  localparam logic [7:0] C_QUOTE = 8'h22;
  localparam logic [7:0] C_PLUS  = 8'h2B;
  localparam logic [7:0] C_COMMA = 8'h2C;
  localparam logic [7:0] C_MINUS = 8'h2D;
  localparam logic [7:0] C_ZERO  = 8'h30;
  localparam logic [7:0] C_NINE  = 8'h39;

  typedef struct {
    logic [7:0] ch;
    logic       closes;
  } text_byte_t;

  typedef struct {
    logic [63:0] value;
    logic        bad;
    logic        sat;
    logic        last;
  } field_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte     = 8'h00;
  logic        record_end    = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [63:0] field_value;
  logic        bad_separator;
  logic        saturated;
  logic        last_field;

  // Bytes still to be offered, and fields the block still owes us, oldest first.
  text_byte_t    byte_stream[$];
  field_result_t awaited_fields[$];

  // Handshake flags sampled at the rising edge, read by the falling-edge drivers.
  logic byte_taken  = 1'b0;
  logic field_taken = 1'b0;
  logic hold_off    = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned tx_wait        = 0;
  int unsigned rx_wait        = 0;
  int unsigned bytes_in       = 0;
  int unsigned records_in     = 0;
  int unsigned fields_checked = 0;
  int unsigned saturated_seen = 0;
  int unsigned bad_seen       = 0;
  int unsigned double_bytes   = 0;
  int unsigned mismatches     = 0;

  // Awkward numbers around the 64-bit boundary, signed zeros and a long zero-padded maximum.
  string corner_values [9] = '{
    "18446744073709551615", "18446744073709551616", "-18446744073709551615",
    "-18446744073709551616", "99999999999999999999", "1844674407370955161",
    "+0", "-0", "00000000000000000000000000018446744073709551615"
  };

  // Field parser state, mirrored from the block's behaviour.
  csvu_pkg::phase_t scan_phase = csvu_pkg::PH_LEAD;
  logic [63:0]      acc_value  = 64'd0;
  int unsigned      kept_chars = 0;
  logic             comma_seen = 1'b0;
  int unsigned      comma_pos  = 0;
  csvu_pkg::cv_t    conv_state = csvu_pkg::CV_PRE;
  logic             minus_seen = 1'b0;
  logic             too_big    = 1'b0;

  csv_unsigned_field_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .record_end    (record_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .field_value   (field_value),
    .bad_separator (bad_separator),
    .saturated     (saturated),
    .last_field    (last_field)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Field parser model
  // ---------------------------------------------------------------------------------------

  // Space, tab, line feed, vertical tab, form feed and carriage return, as strtoull sees them.
  function automatic logic is_white(input logic [7:0] c);
    return (c == C_SPACE) || (c >= C_TAB && c <= 8'h0D);
  endfunction

  function automatic void clear_model_field();
    acc_value  = 64'd0;
    kept_chars = 0;
    comma_seen = 1'b0;
    comma_pos  = 0;
    conv_state = csvu_pkg::CV_PRE;
    minus_seen = 1'b0;
    too_big    = 1'b0;
  endfunction

  // Queues the field in progress as the next expected transfer and starts a fresh one.
  function automatic void close_model_field(input logic bad, input logic last);
    field_result_t r;
    if (too_big) begin
      r.value = '1;
    end else if (minus_seen) begin
      r.value = 64'd0 - acc_value;
    end else begin
      r.value = acc_value;
    end
    r.bad  = bad;
    r.sat  = too_big;
    r.last = last;
    awaited_fields.push_back(r);
    clear_model_field();
  endfunction

  // Once the value would pass 2^64-1 it is frozen and the field reads as saturated.
  function automatic void append_digit(input logic [63:0] d);
    if (!too_big) begin
      if (acc_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
        too_big = 1'b1;
      end else begin
        acc_value = acc_value * 64'd10 + d;
      end
    end
  endfunction

  function automatic void scan_number_char(input logic [7:0] c);
    logic        digit;
    logic [63:0] d;
    digit = (c >= C_ZERO) && (c <= C_NINE);
    d     = {56'd0, c - C_ZERO};
    case (conv_state)
      csvu_pkg::CV_PRE: begin
        if (is_white(c)) begin
          conv_state = csvu_pkg::CV_PRE;
        end else if (c == C_PLUS) begin
          conv_state = csvu_pkg::CV_SIGN;
        end else if (c == C_MINUS) begin
          minus_seen = 1'b1;
          conv_state = csvu_pkg::CV_SIGN;
        end else if (digit) begin
          conv_state = csvu_pkg::CV_DIGITS;
          append_digit(d);
        end else begin
          conv_state = csvu_pkg::CV_DONE;
        end
      end
      csvu_pkg::CV_SIGN, csvu_pkg::CV_DIGITS: begin
        if (digit) begin
          conv_state = csvu_pkg::CV_DIGITS;
          append_digit(d);
        end else begin
          conv_state = csvu_pkg::CV_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  // Text past TEXT_CAP-1 kept characters is dropped and does not count for separator spacing.
  function automatic void keep_model_char(input logic [7:0] c);
    if (kept_chars < csvu_pkg::TEXT_CAP - 1) begin
      kept_chars++;
      scan_number_char(c);
    end
  endfunction

  function automatic void open_field(input logic [7:0] c);
    if (c == C_QUOTE) begin
      scan_phase = csvu_pkg::PH_QUOTED;
    end else begin
      scan_phase = csvu_pkg::PH_PLAIN;
      keep_model_char(c);
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic closes);
    int unsigned queued;
    queued = awaited_fields.size();
    if (c == C_NUL) begin
      // A NUL closes the record by itself; the record end flag on it adds nothing.
      close_model_field(1'b0, 1'b1);
      scan_phase = csvu_pkg::PH_LEAD;
    end else begin
      case (scan_phase)
        csvu_pkg::PH_LEAD: begin
          if (c == C_COMMA) begin
            close_model_field(1'b0, 1'b0);
          end else if (c != C_SPACE && c != C_TAB) begin
            open_field(c);
          end
        end
        csvu_pkg::PH_PLAIN: begin
          if (c == C_COMMA) begin
            close_model_field(1'b0, 1'b0);
            scan_phase = csvu_pkg::PH_LEAD;
          end else begin
            keep_model_char(c);
          end
        end
        csvu_pkg::PH_QUOTED: begin
          if (c == C_QUOTE) begin
            scan_phase = csvu_pkg::PH_AFTER;
          end else if (c == C_COMMA) begin
            // Thousands separators after the first must sit exactly three kept characters
            // after the previous one; any other spacing ends the field and flags it.
            if (comma_seen && (kept_chars - comma_pos) != 3) begin
              close_model_field(1'b1, 1'b0);
              scan_phase = csvu_pkg::PH_LEAD;
            end else begin
              comma_seen = 1'b1;
              comma_pos  = kept_chars;
            end
          end else begin
            keep_model_char(c);
          end
        end
        default: begin
          // After a closing quote, anything but a blank or a comma starts a new field.
          if (c == C_COMMA) begin
            close_model_field(1'b0, 1'b0);
            scan_phase = csvu_pkg::PH_LEAD;
          end else if (c != C_SPACE && c != C_TAB) begin
            close_model_field(1'b0, 1'b0);
            open_field(c);
          end
        end
      endcase
      if (closes) begin
        close_model_field(1'b0, 1'b1);
        scan_phase = csvu_pkg::PH_LEAD;
      end
    end
    if (c == C_NUL || closes) records_in++;
    if (awaited_fields.size() - queued == 2) double_bytes++;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] c, input logic closes);
    byte_stream.push_back('{ch: c, closes: closes});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic push_digits(input int unsigned n);
    repeat (n) push_byte(C_ZERO + 8'($urandom_range(0, 9)), 1'b0);
  endtask

  task automatic close_last_byte();
    byte_stream[byte_stream.size() - 1].closes = 1'b1;
  endtask

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == C_COMMA || c == C_QUOTE);
    return c;
  endfunction

  // A quoted number with thousands separators, mostly well spaced, now and then not.
  // Long runs of groups push the kept text past its cap.
  task automatic push_grouped_number();
    int unsigned groups;
    groups = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 7);
    push_byte(C_QUOTE, 1'b0);
    if ($urandom_range(0, 3) == 0) push_byte(C_MINUS, 1'b0);
    push_digits($urandom_range(1, 3));
    repeat (groups) begin
      push_byte(C_COMMA, 1'b0);
      push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 3);
    end
    push_byte(C_QUOTE, 1'b0);
  endtask

  task automatic add_field();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? C_SPACE : C_TAB, 1'b0);
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: push_byte(C_PLUS, 1'b0);
        1: push_byte(C_MINUS, 1'b0);
        default: ;
      endcase
      push_digits($urandom_range(1, 20));
      if ($urandom_range(0, 4) == 0) push_byte(filler_char(), 1'b0);
    end else if (pick < 45) begin
      push_grouped_number();
    end else if (pick < 52) begin
      // Closed quote, blanks, and sometimes text that opens a new field straight away.
      push_byte(C_QUOTE, 1'b0);
      push_digits($urandom_range(1, 6));
      push_byte(C_QUOTE, 1'b0);
      repeat ($urandom_range(0, 2)) push_byte(C_SPACE, 1'b0);
      if ($urandom_range(0, 1) == 1) push_digits($urandom_range(1, 3));
    end else if (pick < 60) begin
      push_text(corner_values[$urandom_range(0, 8)]);
    end else if (pick < 66) begin
      // Empty field.
    end else if (pick < 72) begin
      if ($urandom_range(0, 1) == 1) begin
        push_digits($urandom_range(64, 80));
      end else begin
        push_digits($urandom_range(10, 19));
        repeat ($urandom_range(50, 70)) push_byte(filler_char(), 1'b0);
      end
    end else if (pick < 80) begin
      // White space, mostly of kinds that only the converter skips, then a number, sometimes signed.
      repeat ($urandom_range(1, 3)) begin
        push_byte(($urandom_range(0, 5) == 5) ? C_SPACE : 8'(C_TAB + $urandom_range(0, 4)),
                  1'b0);
      end
      if ($urandom_range(0, 1) == 1) push_byte($urandom_range(0, 1) ? C_PLUS : C_MINUS, 1'b0);
      push_digits($urandom_range(1, 8));
    end else if (pick < 86) begin
      // Quote left open: later commas are taken as separators until one is misplaced.
      push_byte(C_QUOTE, 1'b0);
      push_digits($urandom_range(1, 4));
    end else begin
      // Raw noise over the whole byte range, NUL included.
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic add_record();
    int unsigned start_len;
    int unsigned fields;
    start_len = byte_stream.size();
    fields    = $urandom_range(1, 5);
    for (int unsigned f = 0; f < fields; f++) begin
      if (f != 0) push_byte(C_COMMA, 1'b0);
      add_field();
    end
    case ($urandom_range(0, 9))
      0, 1: push_byte(C_NUL, 1'b0);
      2: push_byte(C_COMMA, 1'b1);
      default: begin
        if (byte_stream.size() > start_len) begin
          close_last_byte();
        end else begin
          push_byte(C_NUL, 1'b0);
        end
      end
    endcase
  endtask

  // Gap lengths follow the cycle count through stretches with no idling, uniformly drawn
  // idling, and mostly no idling with rare gaps. The offset keeps sender and receiver out of step.
  function automatic int unsigned draw_wait(input int unsigned offset);
    case (((cycle_count + offset) / 1024) % 3)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver, receiver, monitor
  // ---------------------------------------------------------------------------------------

  // The sender keeps valid and the byte steady until the transfer has taken place.
  always @(negedge clk) begin
    text_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (byte_stream.size() != 0) begin
        nxt = byte_stream.pop_front();
        data_byte  <= nxt.ch;
        record_end <= nxt.closes;
        in_valid   <= 1'b1;
        tx_wait    = hold_off ? 0 : draw_wait(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver waits a drawn number of cycles per field, counted while one is on offer.
  always @(negedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      if (field_taken) rx_wait = draw_wait(517);
      if (rx_wait > 0) begin
        if (out_valid) rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Checks each field transfer against the oldest expectation, then feeds the accepted byte
  // to the model; the result queue registers every field, which keeps the two apart.
  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      byte_taken  <= 1'b0;
      field_taken <= 1'b0;
    end else begin
      byte_taken  <= in_valid && in_ready;
      field_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        fields_checked++;
        if (awaited_fields.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX) begin
            $display("tb_top: field %0d not expected: value %h bad %b sat %b last %b",
                     fields_checked, field_value, bad_separator, saturated, last_field);
          end
        end else begin
          want = awaited_fields.pop_front();
          if (field_value !== want.value || bad_separator !== want.bad ||
              saturated !== want.sat || last_field !== want.last) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX) begin
              $display("tb_top: field %0d expected value %h bad %b sat %b last %b",
                       fields_checked, want.value, want.bad, want.sat, want.last);
              $display("tb_top: field %0d      got value %h bad %b sat %b last %b",
                       fields_checked, field_value, bad_separator, saturated, last_field);
            end
          end
          if (want.sat) saturated_seen++;
          if (want.bad) bad_seen++;
        end
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        predict_byte(data_byte, record_end);
      end
    end
  end

  // Two long receiver hold-offs while the sender keeps offering, so the result queue fills
  // and the block has to stall its input.
  initial begin
    wait (bytes_in >= 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    wait (bytes_in >= 900);
    hold_off = 1'b1;
    repeat (250) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: cycle limit of %0d reached with %0d fields outstanding",
               CYCLE_LIMIT, awaited_fields.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    // Directed opening: a wrapped negative, a well-spaced quoted number, text straight after
    // a closing quote, a comma that also ends the record (two fields from one byte), a
    // leading tab and plus sign, a misplaced separator, a high byte and a NUL close.
    push_text(" -1,\"1,234\"x,");
    close_last_byte();
    push_text("\t+7");
    close_last_byte();
    push_text("\"1,23,4");
    push_byte(8'hC8, 1'b0);
    push_byte(C_NUL, 1'b0);
    while (byte_stream.size() < BYTE_TARGET) add_record();

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (byte_stream.size() != 0 || in_valid) @(posedge clk);
    while (awaited_fields.size() != 0) @(posedge clk);
    // Then idle on to catch any stray field after the last expected one.
    repeat (8) @(posedge clk);

    $display("tb_top: %0d bytes in %0d records gave %0d fields, %0d of them saturated,",
             bytes_in, records_in, fields_checked, saturated_seen);
    $display("tb_top: %0d ended by a misplaced separator; %0d bytes closed two fields at once",
             bad_seen, double_bytes);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/csvu_pkg.sv
src/csvu_parse.sv
src/csvu_queue.sv
src/csv_unsigned_field_parser.sv
tb/sv/tb_top.sv
